// File: sv/button_debounce_hold_pump_control_core_assert.svh
// Assertion macros shared by the button debounce and pump control RTL.
`ifndef BUTTON_DEBOUNCE_HOLD_PUMP_CONTROL_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_HOLD_PUMP_CONTROL_CORE_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define BDHP_ASSERT_SAME(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define BDHP_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: sv/bdhp_pkg.sv
// Shared constants and types for the button debounce and pump control core.
package bdhp_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET = 16'd35;
    localparam logic [CFG_DATA_W-1:0] HOLD_RESET = 16'd800;
    localparam logic [CFG_DATA_W-1:0] RUN_RESET = 16'd60;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE_TICKS = 2'd0,
        REG_HOLD_TICKS     = 2'd1,
        REG_RUN_SECONDS    = 2'd2
    } cfg_index_t;

    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

endpackage

// File: sv/button_debounce_hold_pump_control_core.sv
// Top level of the button debounce, press-to-stop and hold-to-start pump control core.
// Each transfer on the input channel is one millisecond tick with the raw active-low
// button level and the relay state; every tick yields exactly one result transfer with
// the stop and start requests, the run length and the debounced level. The whole tick
// is evaluated in the cycle it is accepted and lands in the output register, so its result
// is valid in the cycle after. The core takes one tick per clock cycle while the input side
// is ready; it stays ready while the output register is empty or being drained in the same
// cycle. Configuration writes are accepted in every cycle and take effect for the next tick.
module button_debounce_hold_pump_control_core #(
    parameter int COUNT_BITS = bdhp_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                raw_level,
    input  logic                                relay_on,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                stop_pump,
    output logic                                start_pump,
    output logic [bdhp_pkg::CFG_DATA_W-1:0]     run_seconds,
    output logic                                stable_level,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdhp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bdhp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bdhp_pkg::*;

    `include "button_debounce_hold_pump_control_core_assert.svh"

    localparam int CMP_W = (COUNT_BITS > CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    cfg_data_t debounce_ticks_reg;
    cfg_data_t hold_ticks_reg;
    cfg_data_t run_seconds_cfg_reg;

    logic                  last_raw_reg;
    logic                  debounced_reg;
    logic                  armed_reg;
    logic                  action_taken_reg;
    logic [COUNT_BITS-1:0] since_change_reg;
    logic [COUNT_BITS-1:0] since_press_reg;

    logic                  last_raw_next;
    logic                  debounced_next;
    logic                  armed_next;
    logic                  action_taken_next;
    logic [COUNT_BITS-1:0] since_change_next;
    logic [COUNT_BITS-1:0] since_press_next;

    logic                  out_valid_reg;
    logic                  stop_pump_reg;
    logic                  start_pump_reg;
    cfg_data_t             run_seconds_reg;
    logic                  stable_level_reg;

    logic                  stop_next;
    logic                  start_next;
    cfg_data_t             run_seconds_next;

    logic                  in_accept;
    logic [COUNT_BITS-1:0] change_inc;
    logic [COUNT_BITS-1:0] press_inc;
    logic                  debounce_hit;
    logic                  action_pre;
    logic                  armed_pre;

    assign in_accept = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign stop_pump    = stop_pump_reg;
    assign start_pump   = start_pump_reg;
    assign run_seconds  = run_seconds_reg;
    assign stable_level = stable_level_reg;

    always_comb
    begin
        change_inc = (since_change_reg == CNT_MAX) ? CNT_MAX
                                                   : since_change_reg + COUNT_BITS'(1);
        press_inc  = (since_press_reg == CNT_MAX) ? CNT_MAX
                                                  : since_press_reg + COUNT_BITS'(1);

        last_raw_next     = raw_level;
        since_change_next = (raw_level != last_raw_reg) ? '0 : change_inc;

        debounce_hit = (raw_level != debounced_reg) &&
                       (CMP_W'(since_change_next) >= CMP_W'(debounce_ticks_reg));

        debounced_next   = debounced_reg;
        since_press_next = press_inc;
        armed_pre        = armed_reg;
        action_pre       = action_taken_reg;
        stop_next        = 1'b0;

        if (debounce_hit)
        begin
            debounced_next   = raw_level;
            since_press_next = '0;
            if (!raw_level)
            begin
                action_pre = !armed_reg;
                if (armed_reg && relay_on)
                begin
                    stop_next  = 1'b1;
                    action_pre = 1'b1;
                end
            end
            else
            begin
                armed_pre  = 1'b1;
                action_pre = 1'b0;
            end
        end

        start_next = armed_pre && !debounced_next && !action_pre && !relay_on &&
                     (CMP_W'(since_press_next) >= CMP_W'(hold_ticks_reg));

        armed_next        = armed_pre;
        action_taken_next = action_pre || start_next;
        run_seconds_next  = start_next ? run_seconds_cfg_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg  <= DEBOUNCE_RESET;
            hold_ticks_reg      <= HOLD_RESET;
            run_seconds_cfg_reg <= RUN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS: debounce_ticks_reg  <= cfg_data;
                REG_HOLD_TICKS:     hold_ticks_reg      <= cfg_data;
                REG_RUN_SECONDS:    run_seconds_cfg_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg     <= 1'b1;
            debounced_reg    <= 1'b1;
            armed_reg        <= 1'b1;
            action_taken_reg <= 1'b0;
            since_change_reg <= '0;
            since_press_reg  <= '0;
        end
        else if (in_accept)
        begin
            last_raw_reg     <= last_raw_next;
            debounced_reg    <= debounced_next;
            armed_reg        <= armed_next;
            action_taken_reg <= action_taken_next;
            since_change_reg <= since_change_next;
            since_press_reg  <= since_press_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stop_pump_reg    <= stop_next;
            start_pump_reg   <= start_next;
            run_seconds_reg  <= run_seconds_next;
            stable_level_reg <= debounced_next;
        end
    end

    `BDHP_ASSERT_SAME(a_no_stop_and_start, out_valid && start_pump, !stop_pump,
        "Stop and start requested in the same result.")
    `BDHP_ASSERT_SAME(a_start_while_pressed, out_valid && start_pump, !stable_level,
        "Start requested while the debounced level is released.")
    `BDHP_ASSERT_SAME(a_idle_run_zero, out_valid && !start_pump, run_seconds == '0,
        "Run length is nonzero without a start request.")
    `BDHP_ASSERT_NEXT(a_result_follows_tick, in_valid && in_ready, out_valid,
        "No result follows an accepted tick.")

endmodule

// File: verif/button_debounce_hold_pump_control_core_tb.sv
// Self-checking testbench for the button debounce, press-to-stop and hold-to-start core.
module button_debounce_hold_pump_control_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdhp_pkg::*;

    localparam int COUNT_BITS = COUNT_BITS_DEFAULT;

    typedef struct packed {
        logic      stop;
        logic      start;
        cfg_data_t secs;
        logic      level;
    } pump_request_t;

    class pump_scoreboard;
        cfg_data_t debounce_ticks;
        cfg_data_t hold_ticks;
        cfg_data_t run_secs;
        logic last_raw;
        logic debounced;
        logic armed;
        logic acted;
        logic [COUNT_BITS-1:0] since_change;
        logic [COUNT_BITS-1:0] since_press;
        pump_request_t expected_q[$];
        int fail_count;

        function new();
            debounce_ticks = DEBOUNCE_RESET;
            hold_ticks = HOLD_RESET;
            run_secs = RUN_RESET;
            last_raw = 1'b1;
            debounced = 1'b1;
            armed = 1'b1;
            acted = 1'b0;
            since_change = '0;
            since_press = '0;
            fail_count = 0;
        endfunction

        function void set_reg(cfg_index_t idx, cfg_data_t val);
            case (idx)
                REG_DEBOUNCE_TICKS: debounce_ticks = val;
                REG_HOLD_TICKS:     hold_ticks = val;
                REG_RUN_SECONDS:    run_secs = val;
                default: ;
            endcase
        endfunction

        function void note_tick(logic raw, logic relay);
            pump_request_t r;
            r = '0;
            if (since_change != '1)
                since_change = since_change + 1'b1;
            if (since_press != '1)
                since_press = since_press + 1'b1;
            if (raw != last_raw)
            begin
                last_raw = raw;
                since_change = '0;
            end
            if (raw != debounced && since_change >= debounce_ticks)
            begin
                debounced = raw;
                if (!debounced)
                begin
                    since_press = '0;
                    acted = !armed;
                    if (armed && relay)
                    begin
                        r.stop = 1'b1;
                        acted = 1'b1;
                    end
                end
                else
                begin
                    armed = 1'b1;
                    since_press = '0;
                    acted = 1'b0;
                end
            end
            if (armed && !debounced && !acted && !relay && since_press >= hold_ticks)
            begin
                r.start = 1'b1;
                r.secs = run_secs;
                acted = 1'b1;
            end
            r.level = debounced;
            expected_q.push_back(r);
        endfunction

        function void fail(string msg);
            fail_count++;
            $error("%s", msg);
        endfunction

        function void check_result(logic stop, logic start, cfg_data_t secs, logic level);
            pump_request_t e;
            if (expected_q.size() == 0)
            begin
                fail("result transfer with no pending tick");
                return;
            end
            e = expected_q.pop_front();
            if (stop !== e.stop)
                fail($sformatf("stop_pump: expected %0d, actual %0d", e.stop, stop));
            if (start !== e.start)
                fail($sformatf("start_pump: expected %0d, actual %0d", e.start, start));
            if (secs !== e.secs)
                fail($sformatf("run_seconds: expected %0d, actual %0d", e.secs, secs));
            if (level !== e.level)
                fail($sformatf("stable_level: expected %0d, actual %0d", e.level, level));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic raw_level = 1'b1;
    logic relay_on = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic stop_pump;
    logic start_pump;
    cfg_data_t run_seconds;
    logic stable_level;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_index_t cfg_index = REG_DEBOUNCE_TICKS;
    cfg_data_t cfg_data = '0;

    pump_scoreboard sb = new();
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int stall_left = 0;

    button_debounce_hold_pump_control_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .raw_level(raw_level),
        .relay_on(relay_on),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stop_pump(stop_pump),
        .start_pump(start_pump),
        .run_seconds(run_seconds),
        .stable_level(stable_level),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Results are checked before the tick of the same edge is noted, since a result
    // can never belong to a tick accepted at that edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(stop_pump, start_pump, run_seconds, stable_level);
            if (in_valid && in_ready)
                sb.note_tick(raw_level, relay_on);
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    task automatic send_tick(input logic raw, input logic relay);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_level <= raw;
        relay_on <= relay;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_pattern(input int n, input logic [31:0] raws, input logic [31:0] relays);
        for (int i = 0; i < n; i++)
            send_tick(raws[i], relays[i]);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (sb.pending() != 0 && guard < 5000)
        begin
            guard++;
            @(posedge clk);
        end
        if (sb.pending() != 0)
            sb.fail($sformatf("%0d expected results never arrived", sb.pending()));
        repeat (3) @(posedge clk);
    endtask

    task automatic write_regs(input cfg_data_t deb, input cfg_data_t hold, input cfg_data_t run);
        cfg_index_t idx[3];
        cfg_data_t val[3];
        idx = '{REG_DEBOUNCE_TICKS, REG_HOLD_TICKS, REG_RUN_SECONDS};
        val = '{deb, hold, run};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge clk); while (!cfg_ready);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly clean presses and releases with a little contact bounce, plus some noise.
    task automatic run_presses(input int n_items);
        int sent;
        int kind;
        int len;
        logic target;
        logic relay;
        sent = 0;
        target = 1'b0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 9);
            relay = logic'($urandom_range(0, 1));
            if (kind == 0)
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    send_tick(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
                    sent++;
                end
            end
            else
            begin
                len = $urandom_range(0, 3);
                repeat (len)
                begin
                    send_tick(logic'($urandom_range(0, 1)), relay);
                    sent++;
                end
                len = $urandom_range(0, sb.debounce_ticks + sb.hold_ticks + 4);
                repeat (len)
                begin
                    send_tick(target, (kind == 1) ? logic'($urandom_range(0, 1)) : relay);
                    sent++;
                end
                target = !target;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pattern(3, 32'h0, 32'h0);
        wait_idle();
        write_regs(16'd0, 16'd0, 16'hFFFF);
        send_pattern(7, 32'b0100100, 32'b0001110);
        wait_idle();
        write_regs(16'd2, 16'd3, 16'd0);
        send_pattern(13, 32'b0000001011101, 32'h0);
        wait_idle();

        for (int p = 0; p < 3; p++)
        begin
            in_idle_pct = (p == 0) ? 33 : (p == 1) ? 84 : 0;
            out_idle_pct = (p == 0) ? 84 : (p == 1) ? 33 : 0;
            write_regs(cfg_data_t'($urandom_range(0, 6)), cfg_data_t'($urandom_range(0, 15)),
                       cfg_data_t'($urandom));
            run_presses(130);
            wait_idle();
        end

        write_regs(cfg_data_t'($urandom_range(0, 3)), cfg_data_t'($urandom_range(0, 8)),
                   cfg_data_t'($urandom));
        stall_left = 60;
        run_presses(40);
        wait_idle();

        write_regs(16'd0, 16'hFFFF, cfg_data_t'($urandom));
        send_pattern(4, 32'hF, 32'h0);
        wait_idle();
        write_regs(16'hFFFF, 16'hFFFF, cfg_data_t'($urandom_range(1, 65535)));
        repeat (16) send_tick(1'b0, 1'b0);
        wait_idle();

        if (sb.fail_count == 0)
            $display("button_debounce_hold_pump_control_core: match");
        else
            $display("button_debounce_hold_pump_control_core: mismatch");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("button_debounce_hold_pump_control_core: mismatch");
        $finish;
    end
endmodule

// File: files.f
+incdir+sv
sv/bdhp_pkg.sv
sv/button_debounce_hold_pump_control_core.sv
verif/button_debounce_hold_pump_control_core_tb.sv
